@@ hdl/soft_power_button_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Soft power button controller: assertion macros
// Concurrent check wrappers. In synthesis builds they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef SOFT_POWER_BUTTON_CONTROLLER_DEFINES_SVH
`define SOFT_POWER_BUTTON_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// check outside reset
`define SPBC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every edge, reset included
`define SPBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPBC_ASSERT(lbl, clk, rst, prop, msg)
`define SPBC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hdl/spbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Soft power button controller package
// Register indexes, widths, LED and press codes, shared structs.
// ----------------------------------------------------------------------------
package spbc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_DELAY      = 3'd0,
      CSR_OFF_ENABLE_DELAY = 3'd1,
      CSR_PRESS_TICKS      = 3'd2,
      CSR_CANCEL_TICKS     = 3'd3,
      CSR_SSR_INVERT       = 3'd4
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] START_DELAY_RST      = 16'd2;
   localparam logic [CSR_DATA_W-1:0] OFF_ENABLE_DELAY_RST = 16'd32;
   localparam logic [CSR_DATA_W-1:0] PRESS_TICKS_RST      = 16'd4;
   localparam logic [CSR_DATA_W-1:0] CANCEL_TICKS_RST     = 16'd48;

   typedef enum logic [1:0] {
      LED_OFF   = 2'd0,
      LED_ON    = 2'd1,
      LED_BLINK = 2'd2
   } led_mode_type;

   typedef enum logic [3:0] {
      PRESS_RELEASED  = 4'b0001,
      PRESS_DELAYING  = 4'b0010,
      PRESS_ACTIVE    = 4'b0100,
      PRESS_CANCELLED = 4'b1000
   } press_mode_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] start_delay;
      logic [CSR_DATA_W-1:0] off_enable_delay;
      logic [CSR_DATA_W-1:0] press_ticks;
      logic [CSR_DATA_W-1:0] cancel_ticks;
      logic                  ssr_invert;
   } cfg_type;

   typedef struct packed {
      logic         ssr_drive;
      logic         power_on;
      led_mode_type red_mode;
      logic         blue_mode;
      logic         green_mode;
   } result_type;

endpackage

@@ hdl/spbc_csr.sv @@
// ----------------------------------------------------------------------------
// Soft power button controller: configuration registers
// Holds the delay, hold-time and relay polarity settings.
// ----------------------------------------------------------------------------
module spbc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spbc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output spbc_pkg::cfg_type                  cfg
);

   spbc_pkg::cfg_type cfg_ff;
   spbc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            spbc_pkg::CSR_START_DELAY:      cfg_in.start_delay      = csr_wdata;
            spbc_pkg::CSR_OFF_ENABLE_DELAY: cfg_in.off_enable_delay = csr_wdata;
            spbc_pkg::CSR_PRESS_TICKS:      cfg_in.press_ticks      = csr_wdata;
            spbc_pkg::CSR_CANCEL_TICKS:     cfg_in.cancel_ticks     = csr_wdata;
            spbc_pkg::CSR_SSR_INVERT:       cfg_in.ssr_invert       = csr_wdata[0];
            default:                        cfg_in = cfg_ff; // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay      <= spbc_pkg::START_DELAY_RST;
         cfg_ff.off_enable_delay <= spbc_pkg::OFF_ENABLE_DELAY_RST;
         cfg_ff.press_ticks      <= spbc_pkg::PRESS_TICKS_RST;
         cfg_ff.cancel_ticks     <= spbc_pkg::CANCEL_TICKS_RST;
         cfg_ff.ssr_invert       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/spbc_core.sv @@
// ----------------------------------------------------------------------------
// Soft power button controller: control state and poll logic
// Updates press, power and LED state for one poll and forms its result.
// ----------------------------------------------------------------------------
`include "soft_power_button_controller_defines.svh"

module spbc_core #(
   parameter int unsigned TIME_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [TIME_BITS-1:0]    now,
   input  logic                    button_pressed,
   input  logic                    off_asserted,
   input  spbc_pkg::cfg_type       cfg,
   output spbc_pkg::result_type    result
);

   localparam int unsigned CMP_W =
      (TIME_BITS > spbc_pkg::CSR_DATA_W) ? TIME_BITS : spbc_pkg::CSR_DATA_W;

   logic                         start_armed_ff, start_armed_in;
   logic                         off_armed_ff, off_armed_in;
   logic                         power_ff, power_in;
   logic                         off_level_ff, off_level_in;
   spbc_pkg::press_mode_type     press_mode_ff, press_mode_in;
   logic [TIME_BITS-1:0]         press_start_ff, press_start_in;
   spbc_pkg::led_mode_type       red_ff, red_in;
   logic                         blue_ff, blue_in;
   logic                         green_ff, green_in;

   logic [TIME_BITS-1:0]         hold;
   logic [CMP_W-1:0]             now_x;
   logic [CMP_W-1:0]             hold_x;
   logic                         before_start;
   logic                         before_off;
   logic                         hold_past_press;
   logic                         hold_past_cancel;

   assign hold             = now - press_start_ff;
   assign now_x            = CMP_W'(now);
   assign hold_x           = CMP_W'(hold);
   assign before_start     = now_x < CMP_W'(cfg.start_delay);
   assign before_off       = now_x < CMP_W'(cfg.off_enable_delay);
   assign hold_past_press  = hold_x >= CMP_W'(cfg.press_ticks);
   assign hold_past_cancel = hold_x >= CMP_W'(cfg.cancel_ticks);

   always_comb begin
      start_armed_in = start_armed_ff;
      off_armed_in   = off_armed_ff;
      power_in       = power_ff;
      off_level_in   = off_level_ff;
      press_mode_in  = press_mode_ff;
      press_start_in = press_start_ff;
      red_in         = red_ff;
      blue_in        = blue_ff;
      green_in       = green_ff;

      if (start_armed_ff || !before_start) begin
         // first poll past the start delay: set up LEDs, held button is void
         if (!start_armed_ff) begin
            start_armed_in = 1'b1;
            red_in         = power_ff ? spbc_pkg::LED_OFF : spbc_pkg::LED_BLINK;
            blue_in        = power_ff;
            green_in       = button_pressed;
            press_mode_in  = button_pressed ? spbc_pkg::PRESS_CANCELLED
                                            : spbc_pkg::PRESS_RELEASED;
         end

         if (!button_pressed) begin
            if (press_mode_in != spbc_pkg::PRESS_RELEASED) begin
               if (press_mode_in == spbc_pkg::PRESS_ACTIVE) begin
                  power_in = !power_ff;
                  red_in   = power_ff ? spbc_pkg::LED_ON : spbc_pkg::LED_OFF;
                  blue_in  = !power_ff;
               end
               green_in      = 1'b0;
               press_mode_in = spbc_pkg::PRESS_RELEASED;
            end
         end else begin
            case (press_mode_in)
               spbc_pkg::PRESS_RELEASED: begin
                  press_start_in = now;
                  green_in       = 1'b1;
                  press_mode_in  = spbc_pkg::PRESS_DELAYING;
               end
               spbc_pkg::PRESS_DELAYING: begin
                  // preview the toggled power on the LEDs
                  if (hold_past_press) begin
                     red_in        = power_ff ? spbc_pkg::LED_ON : spbc_pkg::LED_OFF;
                     blue_in       = !power_ff;
                     press_mode_in = spbc_pkg::PRESS_ACTIVE;
                  end
               end
               spbc_pkg::PRESS_ACTIVE: begin
                  if (hold_past_cancel) begin
                     red_in        = power_ff ? spbc_pkg::LED_OFF : spbc_pkg::LED_ON;
                     blue_in       = power_ff;
                     green_in      = 1'b0;
                     press_mode_in = spbc_pkg::PRESS_CANCELLED;
                  end
               end
               default: begin
               end
            endcase
         end

         if (!off_armed_ff && before_off) begin
            off_level_in = off_asserted;
         end else begin
            off_armed_in = 1'b1;
            if (off_asserted && !off_level_ff) begin
               power_in = 1'b0;
               red_in   = spbc_pkg::LED_ON;
               blue_in  = 1'b0;
               if (press_mode_in != spbc_pkg::PRESS_RELEASED) begin
                  press_mode_in = spbc_pkg::PRESS_CANCELLED;
                  green_in      = 1'b0;
               end
            end
            off_level_in = off_asserted;
         end
      end
   end

   assign result.ssr_drive  = power_in ^ cfg.ssr_invert;
   assign result.power_on   = power_in;
   assign result.red_mode   = red_in;
   assign result.blue_mode  = blue_in;
   assign result.green_mode = green_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_armed_ff <= 1'b0;
         off_armed_ff   <= 1'b0;
         power_ff       <= 1'b0;
         off_level_ff   <= 1'b0;
         press_mode_ff  <= spbc_pkg::PRESS_RELEASED;
         press_start_ff <= '0;
         red_ff         <= spbc_pkg::LED_OFF;
         blue_ff        <= 1'b0;
         green_ff       <= 1'b0;
      end else if (fire) begin
         start_armed_ff <= start_armed_in;
         off_armed_ff   <= off_armed_in;
         power_ff       <= power_in;
         off_level_ff   <= off_level_in;
         press_mode_ff  <= press_mode_in;
         press_start_ff <= press_start_in;
         red_ff         <= red_in;
         blue_ff        <= blue_in;
         green_ff       <= green_in;
      end
   end

   `SPBC_ASSERT(a_idle_before_start, clock, reset, !start_armed_ff |-> (press_mode_ff == spbc_pkg::PRESS_RELEASED && !power_ff && !green_ff), "state moved before start")
   `SPBC_ASSERT(a_off_after_start, clock, reset, off_armed_ff |-> start_armed_ff, "power-off armed before start")
   `SPBC_ASSERT(a_power_only_on_poll, clock, reset, !fire |=> $stable(power_ff), "power changed without a poll")
   `SPBC_ASSERT(a_green_tracks_press, clock, reset, green_ff |-> (press_mode_ff != spbc_pkg::PRESS_RELEASED), "green LED on with no press")

endmodule

@@ hdl/soft_power_button_controller.sv @@
// ----------------------------------------------------------------------------
// Soft power button controller
// Each request is one poll: the tick time plus the debounced button and
// power-off levels. Button handling starts once the tick time reaches
// start_delay; a press held at least press_ticks and then released toggles
// power, holding to cancel_ticks aborts it. Once the tick time reaches
// off_enable_delay, a rising power-off level forces power off. Every poll
// returns one response with the relay drive, the power state and the three
// LED modes. While rsp_ready is high the block takes one request per clock:
// a request is held in the input register, is resolved by the control logic
// on its way into the response register, and then drives rsp_*.
// Back-to-back requests stream at one per clock while rsp_ready stays high.
// Write configuration only while no poll is in flight.
// ----------------------------------------------------------------------------
`include "soft_power_button_controller_defines.svh"

module soft_power_button_controller #(
   parameter int unsigned TIME_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,

   // poll requests
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [TIME_BITS-1:0]               req_now,
   input  logic                               req_button_pressed,
   input  logic                               req_off_asserted,

   // poll responses
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ssr_drive,
   output logic                               rsp_power_on,
   output logic [1:0]                         rsp_red_mode,
   output logic                               rsp_blue_mode,
   output logic                               rsp_green_mode,

   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spbc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   spbc_pkg::cfg_type       cfg;
   spbc_pkg::result_type    result;

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic [TIME_BITS-1:0]    now_ff;
   logic                    button_ff;
   logic                    off_ff;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   spbc_pkg::result_type    rsp_ff;

   logic                    advance;
   logic                    fire;
   logic                    take;

   // response slot frees when empty or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   // resolve the held poll as it moves into the response register
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload: capture inputs on accept only, the result on fire
   always_ff @(posedge clock) begin
      if (take) begin
         now_ff    <= req_now;
         button_ff <= req_button_pressed;
         off_ff    <= req_off_asserted;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   spbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spbc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .now            (now_ff),
      .button_pressed (button_ff),
      .off_asserted   (off_ff),
      .cfg            (cfg),
      .result         (result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ssr_drive  = rsp_ff.ssr_drive;
   assign rsp_power_on   = rsp_ff.power_on;
   assign rsp_red_mode   = rsp_ff.red_mode;
   assign rsp_blue_mode  = rsp_ff.blue_mode;
   assign rsp_green_mode = rsp_ff.green_mode;

   `SPBC_ASSERT(a_no_lost_request, clock, reset, (in_valid_ff && !advance) |=> in_valid_ff, "held request dropped")
   `SPBC_ASSERT(a_fire_fills_rsp, clock, reset, fire |=> rsp_valid_ff, "resolved request gave no response")
   `SPBC_ASSERT(a_rsp_held_on_stall, clock, reset, (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)), "stalled response changed")
   `SPBC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!in_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule
